// ===== hdl/velocity_command_shaper_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Velocity command shaper assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_COMMAND_SHAPER_UNIT_DEFINES_SVH
`define VELOCITY_COMMAND_SHAPER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define VCS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("velocity command shaper assertion failed");
`define VCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  `VCS_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))
`else
`define VCS_ASSERT(lbl, clk, rst_n, prop)
`define VCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/vcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Velocity command shaper package
// Widths, register indexes, stage payload type and shared arithmetic.
// ----------------------------------------------------------------------------
package vcs_pkg;

  localparam int VEL_W     = 16;
  localparam int FRAC_PRE  = 8;
  localparam int XY_W      = 27;
  localparam int XY_PAD    = XY_W - VEL_W - FRAC_PRE;
  localparam int Z_W       = 27;
  localparam int RND_SH    = 12;
  localparam int ERR_W     = Z_W - RND_SH;
  localparam int GAIN_W    = 16;
  localparam int PROD_W    = 32;
  localparam int TERM_W    = PROD_W - RND_SH;
  localparam int SUM_W     = TERM_W + 1;
  localparam int LIM_W     = 15;
  localparam int TOA_W     = 13;
  localparam int DB_W      = 10;
  localparam int MODE_W    = 2;
  localparam int CFG_W     = 60;
  localparam int CFG_IDX_W = 3;
  localparam int MAX_STEPS = 24;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_MODE     = 3'd0;
  localparam cfg_idx_t REG_MAX_FWD  = 3'd1;
  localparam cfg_idx_t REG_MAX_LAT  = 3'd2;
  localparam cfg_idx_t REG_MAX_TURN = 3'd3;
  localparam cfg_idx_t REG_FWD_CAP  = 3'd4;
  localparam cfg_idx_t REG_GAIN     = 3'd5;
  localparam cfg_idx_t REG_TOA      = 3'd6;
  localparam cfg_idx_t REG_DEADBAND = 3'd7;

  localparam int MODE_DB_BIT  = 0;
  localparam int MODE_FWD_BIT = 1;

  typedef struct packed {
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic signed [VEL_W-1:0] yaw;
    logic                    hd;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
  } cordic_t;

  // atan(2^-i) in Q.24 radians
  function automatic logic signed [Z_W-1:0] atan_q24(input int unsigned i);
    case (i)
      0:       return 27'sd13176795;
      1:       return 27'sd7778716;
      2:       return 27'sd4110060;
      3:       return 27'sd2086331;
      4:       return 27'sd1047214;
      5:       return 27'sd524117;
      6:       return 27'sd262123;
      7:       return 27'sd131069;
      8:       return 27'sd65536;
      9:       return 27'sd32768;
      10:      return 27'sd16384;
      11:      return 27'sd8192;
      12:      return 27'sd4096;
      13:      return 27'sd2048;
      14:      return 27'sd1024;
      15:      return 27'sd512;
      16:      return 27'sd256;
      17:      return 27'sd128;
      18:      return 27'sd64;
      19:      return 27'sd32;
      20:      return 27'sd16;
      21:      return 27'sd8;
      22:      return 27'sd4;
      23:      return 27'sd2;
      default: return '0;
    endcase
  endfunction

  // zero limit means no clamp
  function automatic logic signed [VEL_W-1:0] clamp_axis(
    input logic signed [VEL_W-1:0] v,
    input logic [LIM_W-1:0]        lim
  );
    logic signed [VEL_W:0] ve;
    logic signed [VEL_W:0] le;
    ve = {v[VEL_W-1], v};
    le = $signed({2'b00, lim});
    if (lim == '0) begin
      return v;
    end else if (ve > le) begin
      return {1'b0, lim};
    end else if (ve < -le) begin
      return VEL_W'(0) - {1'b0, lim};
    end else begin
      return v;
    end
  endfunction

  function automatic logic signed [VEL_W-1:0] deadband(
    input logic signed [VEL_W-1:0] v,
    input logic [DB_W-1:0]         zero_th,
    input logic [DB_W-1:0]         min_eff
  );
    logic signed [VEL_W:0] ve;
    logic [VEL_W:0]        mag;
    ve  = {v[VEL_W-1], v};
    mag = v[VEL_W-1] ? unsigned'(-ve) : unsigned'(ve);
    if (mag < {{(VEL_W+1-DB_W){1'b0}}, zero_th}) begin
      return '0;
    end else if (mag >= {{(VEL_W+1-DB_W){1'b0}}, min_eff}) begin
      return v;
    end else if (v[VEL_W-1]) begin
      return VEL_W'(0) - {{(VEL_W-DB_W){1'b0}}, min_eff};
    end else begin
      return {{(VEL_W-DB_W){1'b0}}, min_eff};
    end
  endfunction

endpackage

// ===== hdl/vcs_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Velocity command channel
// Valid/ready channel carrying one body velocity command item.
// ----------------------------------------------------------------------------
interface vcs_cmd_if;
  logic                            valid;
  logic                            ready;
  logic signed [vcs_pkg::VEL_W-1:0] cmd_forward;
  logic signed [vcs_pkg::VEL_W-1:0] cmd_lateral;
  logic signed [vcs_pkg::VEL_W-1:0] cmd_turn;

  modport source (output valid, output cmd_forward, output cmd_lateral,
                  output cmd_turn, input ready);
  modport sink   (input valid, input cmd_forward, input cmd_lateral,
                  input cmd_turn, output ready);
endinterface

// ===== hdl/vcs_out_if.sv =====
// ----------------------------------------------------------------------------
// Shaped velocity channel
// Valid/ready channel carrying one shaped velocity command item.
// ----------------------------------------------------------------------------
interface vcs_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [vcs_pkg::VEL_W-1:0] out_forward;
  logic signed [vcs_pkg::VEL_W-1:0] out_lateral;
  logic signed [vcs_pkg::VEL_W-1:0] out_turn;

  modport source (output valid, output out_forward, output out_lateral,
                  output out_turn, input ready);
  modport sink   (input valid, input out_forward, input out_lateral,
                  input out_turn, output ready);
endinterface

// ===== hdl/velocity_command_shaper_unit.sv =====
// ----------------------------------------------------------------------------
// Velocity command shaper
// Heading correction, per-axis clamp and deadband for body velocity commands.
// ----------------------------------------------------------------------------
// Fully pipelined: one command item is accepted every cycle unless output
// backpressure stalls the pipeline. Each item passes CORDIC_STEPS + 6
// registers (one input stage, one register per CORDIC rotation, then round,
// gain multiply, add/saturate, clamp and deadband stages). Every stage holds
// its item under backpressure and fills bubbles, so stalls only add latency.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must write it only while idle, which the block itself does not enforce.
module velocity_command_shaper_unit #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vcs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [vcs_pkg::CFG_W-1:0]       cfg_data_i,
  vcs_cmd_if.sink                         cmd_i,
  vcs_out_if.source                       res_o
);

  localparam int NPOST = 5;

  // configuration
  logic [vcs_pkg::MODE_W-1:0] mode_q;
  logic [vcs_pkg::LIM_W-1:0]  max_fwd_q;
  logic [vcs_pkg::LIM_W-1:0]  max_lat_q;
  logic [vcs_pkg::LIM_W-1:0]  max_turn_q;
  logic [vcs_pkg::LIM_W-1:0]  fwd_cap_q;
  logic [vcs_pkg::GAIN_W-1:0] gain_q;
  logic [vcs_pkg::TOA_W-1:0]  toa_q;
  logic [vcs_pkg::CFG_W-1:0]  db_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 2'd3;
      max_fwd_q  <= 15'd12288;
      max_lat_q  <= 15'd4096;
      max_turn_q <= 15'd12288;
      fwd_cap_q  <= 15'd2662;
      gain_q     <= 16'd4915;
      toa_q      <= 13'd1787;
      db_q       <= 60'd139026912467170427;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vcs_pkg::REG_MODE:     mode_q     <= cfg_data_i[vcs_pkg::MODE_W-1:0];
        vcs_pkg::REG_MAX_FWD:  max_fwd_q  <= cfg_data_i[vcs_pkg::LIM_W-1:0];
        vcs_pkg::REG_MAX_LAT:  max_lat_q  <= cfg_data_i[vcs_pkg::LIM_W-1:0];
        vcs_pkg::REG_MAX_TURN: max_turn_q <= cfg_data_i[vcs_pkg::LIM_W-1:0];
        vcs_pkg::REG_FWD_CAP:  fwd_cap_q  <= cfg_data_i[vcs_pkg::LIM_W-1:0];
        vcs_pkg::REG_GAIN:     gain_q     <= cfg_data_i[vcs_pkg::GAIN_W-1:0];
        vcs_pkg::REG_TOA:      toa_q      <= cfg_data_i[vcs_pkg::TOA_W-1:0];
        vcs_pkg::REG_DEADBAND: db_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic fwd_mode;
  logic db_en;
  assign fwd_mode = mode_q[vcs_pkg::MODE_FWD_BIT];
  assign db_en    = mode_q[vcs_pkg::MODE_DB_BIT];

  // input stage and CORDIC chain
  vcs_pkg::cordic_t          cd [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0]     cv;
  logic [CORDIC_STEPS:0]     cr;
  vcs_pkg::cordic_t          prep_d;
  vcs_pkg::cordic_t          prep_q;
  logic                      prep_vld_q;
  logic                      prep_rdy;
  logic [NPOST-1:0]          pv_q;
  logic [NPOST-1:0]          pr;
  logic [vcs_pkg::VEL_W:0]   vx_ext;
  logic [vcs_pkg::VEL_W:0]   ax;

  assign prep_rdy    = !prep_vld_q || cr[0];
  assign cmd_i.ready = prep_rdy;

  always_comb begin
    vx_ext    = {cmd_i.cmd_forward[vcs_pkg::VEL_W-1], cmd_i.cmd_forward};
    ax        = vx_ext[vcs_pkg::VEL_W] ? (~vx_ext + 1'b1) : vx_ext;
    prep_d.vx  = cmd_i.cmd_forward;
    prep_d.vy  = cmd_i.cmd_lateral;
    prep_d.yaw = cmd_i.cmd_turn;
    prep_d.hd  = fwd_mode && (cmd_i.cmd_lateral != '0);
    prep_d.x   = {{vcs_pkg::XY_PAD{1'b0}}, ax[vcs_pkg::VEL_W-1:0],
                  {vcs_pkg::FRAC_PRE{1'b0}}};
    prep_d.y   = {{vcs_pkg::XY_PAD{cmd_i.cmd_lateral[vcs_pkg::VEL_W-1]}},
                  cmd_i.cmd_lateral, {vcs_pkg::FRAC_PRE{1'b0}}};
    prep_d.z   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_vld_q <= 1'b0;
    end else if (prep_rdy) begin
      prep_vld_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prep_rdy) begin
      prep_q <= prep_d;
    end
  end

  assign cd[0] = prep_q;
  assign cv[0] = prep_vld_q;
  assign cr[CORDIC_STEPS] = pr[0];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    vcs_cordic_stage #(
      .STEP (k)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[k]),
      .ready_o (cr[k]),
      .data_i  (cd[k]),
      .valid_o (cv[k+1]),
      .ready_i (cr[k+1]),
      .data_o  (cd[k+1])
    );
  end

  // post stage handshake
  always_comb begin
    pr[NPOST-1] = !pv_q[NPOST-1] || res_o.ready;
    for (int k = NPOST-2; k >= 0; k--) begin
      pr[k] = !pv_q[k] || pr[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else begin
      if (pr[0]) pv_q[0] <= cv[CORDIC_STEPS];
      for (int k = 1; k < NPOST; k++) begin
        if (pr[k]) pv_q[k] <= pv_q[k-1];
      end
    end
  end

  // round heading error, turn-only check
  vcs_pkg::cordic_t                    cf;
  logic signed [vcs_pkg::Z_W-1:0]      z_rnd;
  logic signed [vcs_pkg::ERR_W-1:0]    err;
  logic [vcs_pkg::ERR_W-1:0]           aerr;
  logic                                kill_fwd;
  logic signed [vcs_pkg::VEL_W-1:0]    vx1_q, vy1_q, yaw1_q;
  logic signed [vcs_pkg::ERR_W-1:0]    err1_q;
  logic                                hd1_q;

  assign cf = cd[CORDIC_STEPS];

  always_comb begin
    z_rnd    = cf.z + (vcs_pkg::Z_W)'(2048);
    err      = z_rnd[vcs_pkg::Z_W-1:vcs_pkg::RND_SH];
    aerr     = err[vcs_pkg::ERR_W-1] ? unsigned'(-err) : unsigned'(err);
    kill_fwd = cf.hd &&
               (aerr >= {{(vcs_pkg::ERR_W-vcs_pkg::TOA_W){1'b0}}, toa_q});
  end

  always_ff @(posedge clk_i) begin
    if (pr[0]) begin
      vx1_q  <= kill_fwd ? '0 : cf.vx;
      vy1_q  <= cf.hd ? '0 : cf.vy;
      yaw1_q <= cf.yaw;
      err1_q <= cf.hd ? err : '0;
      hd1_q  <= cf.hd;
    end
  end

  // gain multiply
  logic signed [vcs_pkg::PROD_W-1:0] prod_d;
  logic signed [vcs_pkg::PROD_W-1:0] prod2_q;
  logic signed [vcs_pkg::VEL_W-1:0]  vx2_q, vy2_q, yaw2_q;
  logic                              hd2_q;

  assign prod_d = (vcs_pkg::PROD_W)'($signed({1'b0, gain_q})) *
                  (vcs_pkg::PROD_W)'(err1_q);

  always_ff @(posedge clk_i) begin
    if (pr[1]) begin
      prod2_q <= prod_d;
      vx2_q   <= vx1_q;
      vy2_q   <= vy1_q;
      yaw2_q  <= yaw1_q;
      hd2_q   <= hd1_q;
    end
  end

  // add correction to yaw and saturate
  logic signed [vcs_pkg::PROD_W-1:0] prod_rnd;
  logic signed [vcs_pkg::TERM_W-1:0] term;
  logic signed [vcs_pkg::SUM_W-1:0]  yaw_sum;
  logic signed [vcs_pkg::VEL_W-1:0]  yaw_sat;
  logic signed [vcs_pkg::VEL_W-1:0]  vx3_q, vy3_q, yaw3_q;

  always_comb begin
    prod_rnd = prod2_q + (vcs_pkg::PROD_W)'(2048);
    term     = prod_rnd[vcs_pkg::PROD_W-1:vcs_pkg::RND_SH];
    yaw_sum  = {{(vcs_pkg::SUM_W-vcs_pkg::VEL_W){yaw2_q[vcs_pkg::VEL_W-1]}}, yaw2_q}
               + {term[vcs_pkg::TERM_W-1], term};
    if (!hd2_q) begin
      yaw_sat = yaw2_q;
    end else if (yaw_sum > (vcs_pkg::SUM_W)'(32767)) begin
      yaw_sat = 16'sh7FFF;
    end else if (yaw_sum < -(vcs_pkg::SUM_W)'(32768)) begin
      yaw_sat = 16'sh8000;
    end else begin
      yaw_sat = yaw_sum[vcs_pkg::VEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pr[2]) begin
      vx3_q  <= vx2_q;
      vy3_q  <= vy2_q;
      yaw3_q <= yaw_sat;
    end
  end

  // per-axis clamp
  logic [vcs_pkg::LIM_W-1:0]        yaw_lim;
  logic signed [vcs_pkg::VEL_W-1:0] vx4_q, vy4_q, yaw4_q;

  assign yaw_lim = (fwd_mode && (fwd_cap_q < max_turn_q)) ? fwd_cap_q : max_turn_q;

  always_ff @(posedge clk_i) begin
    if (pr[3]) begin
      vx4_q  <= vcs_pkg::clamp_axis(vx3_q, max_fwd_q);
      vy4_q  <= vcs_pkg::clamp_axis(vy3_q, max_lat_q);
      yaw4_q <= vcs_pkg::clamp_axis(yaw3_q, yaw_lim);
    end
  end

  // deadband and output register
  logic signed [vcs_pkg::VEL_W-1:0] vx5_q, vy5_q, yaw5_q;

  always_ff @(posedge clk_i) begin
    if (pr[4]) begin
      if (db_en) begin
        vx5_q  <= vcs_pkg::deadband(vx4_q,  db_q[9:0],   db_q[39:30]);
        vy5_q  <= vcs_pkg::deadband(vy4_q,  db_q[19:10], db_q[49:40]);
        yaw5_q <= vcs_pkg::deadband(yaw4_q, db_q[29:20], db_q[59:50]);
      end else begin
        vx5_q  <= vx4_q;
        vy5_q  <= vy4_q;
        yaw5_q <= yaw4_q;
      end
    end
  end

  assign res_o.valid       = pv_q[NPOST-1];
  assign res_o.out_forward = vx5_q;
  assign res_o.out_lateral = vy5_q;
  assign res_o.out_turn    = yaw5_q;

  // checks
  logic                          in_acc;
  logic                          out_acc;
  logic [CORDIC_STEPS+NPOST:0]   occ;
  int                            occ_cnt;
  int                            occ_delta;

  assign in_acc    = cmd_i.valid && cmd_i.ready;
  assign out_acc   = res_o.valid && res_o.ready;
  assign occ       = {pv_q, cv};
  assign occ_cnt   = $countones(occ);
  assign occ_delta = int'(in_acc) - int'(out_acc);

`include "velocity_command_shaper_unit_defines.svh"

  `VCS_ASSERT(a_ready_only_when_full, clk_i, rst_ni, !cmd_i.ready |-> (&occ))
  `VCS_ASSERT_NEXT(a_item_count, clk_i, rst_ni, 1'b1, occ_cnt == $past(occ_cnt + occ_delta))
  `VCS_ASSERT_NEXT(a_prep_holds, clk_i, rst_ni, prep_vld_q && !cr[0], prep_vld_q && $stable(prep_q))

endmodule

// ===== hdl/vcs_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// Velocity command shaper CORDIC stage
// One vectoring CORDIC rotation with its own valid/ready pipeline register.
// ----------------------------------------------------------------------------
module vcs_cordic_stage #(
  parameter int unsigned STEP = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  vcs_pkg::cordic_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output vcs_pkg::cordic_t data_o
);

  logic                                valid_q;
  vcs_pkg::cordic_t                    data_d;
  vcs_pkg::cordic_t                    data_q;
  logic signed [vcs_pkg::XY_W-1:0]     dx;
  logic signed [vcs_pkg::XY_W-1:0]     dy;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    dx     = data_i.y >>> STEP;
    dy     = data_i.x >>> STEP;
    data_d = data_i;
    if (!data_i.y[vcs_pkg::XY_W-1]) begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + vcs_pkg::atan_q24(STEP);
    end else begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - vcs_pkg::atan_q24(STEP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== verif/tb_velocity_command_shaper_unit.sv =====
// ----------------------------------------------------------------------------
// Velocity command shaper testbench
// Drives command items through the cmd channel and checks every shaped item
// against known values or a behavioral model of heading correction, clamp and
// deadband. A directed table runs first, then random phases with new register
// settings, sender gaps, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_velocity_command_shaper_unit;

  localparam int CORDIC_STEPS    = 16;
  localparam int PIPE_LATENCY    = CORDIC_STEPS + 6;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 128;
  localparam int PRESSURE_PHASE  = 4;
  localparam int HOLD_CYCLES     = 300;
  localparam int MAX_GAP         = 16;
  localparam int MAX_REPORTS     = 60;
  localparam int LIMIT_CYCLES    = 200000;

  localparam logic [vcs_pkg::CFG_W-1:0] DB_RAISE =
    (vcs_pkg::CFG_W'(300) << 30) | (vcs_pkg::CFG_W'(1023) << 40) |
    (vcs_pkg::CFG_W'(1) << 50);

  localparam longint HEADING_ATAN [0:23] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  typedef struct packed {
    logic signed [vcs_pkg::VEL_W-1:0] forward;
    logic signed [vcs_pkg::VEL_W-1:0] lateral;
    logic signed [vcs_pkg::VEL_W-1:0] turn;
  } vel_cmd_t;

  typedef struct packed {
    logic signed [vcs_pkg::VEL_W-1:0] forward;
    logic signed [vcs_pkg::VEL_W-1:0] lateral;
    logic signed [vcs_pkg::VEL_W-1:0] turn;
  } vel_out_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e                 kind;
    bit                        known;
    vcs_pkg::cfg_idx_t         idx;
    logic [vcs_pkg::CFG_W-1:0] value;
    vel_cmd_t                  cmd;
    vel_out_t                  want;
  } row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [vcs_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [vcs_pkg::CFG_W-1:0]     cfg_data_i;

  vcs_cmd_if cmd_bus ();
  vcs_out_if res_bus ();

  velocity_command_shaper_unit #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cmd_i     (cmd_bus),
    .res_o     (res_bus)
  );

  // register shadow
  longint                    mode_bits;
  longint                    fwd_limit;
  longint                    lat_limit;
  longint                    turn_limit;
  longint                    fwd_turn_cap;
  longint                    heading_gain;
  longint                    turn_only_thr;
  logic [vcs_pkg::CFG_W-1:0] db_fields;

  vel_out_t pending_shaped[$];
  row_t     directed[$];
  int       mismatch_count;
  int       gap_pct;
  int       stall_pct;
  int       hold_requests;
  int       hold_served;
  int       hold_left;
  int       cycle_count;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- model
  function automatic longint heading_error_q12(longint ax, longint ay);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    int     i;
    x = ax * 256;
    y = ay * 256;
    z = 0;
    for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + HEADING_ATAN[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - HEADING_ATAN[i];
      end
    end
    return (z + 2048) >>> 12;
  endfunction

  function automatic longint clamp_to(longint v, longint lim);
    if (lim <= 0) return v;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint apply_deadband(longint v, longint zero_th, longint min_eff);
    longint mag;
    mag = (v < 0) ? -v : v;
    if (mag < zero_th) return 0;
    if (mag >= min_eff) return v;
    return (v < 0) ? -min_eff : min_eff;
  endfunction

  function automatic longint db_field(int k);
    return longint'(db_fields[k*vcs_pkg::DB_W +: vcs_pkg::DB_W]);
  endfunction

  function automatic vel_out_t shape_command(vel_cmd_t c);
    longint   vx;
    longint   vy;
    longint   yaw;
    longint   ax;
    longint   err;
    longint   aerr;
    longint   yaw_lim;
    bit       fwd_on;
    vel_out_t r;
    vx     = c.forward;
    vy     = c.lateral;
    yaw    = c.turn;
    fwd_on = mode_bits[vcs_pkg::MODE_FWD_BIT];
    if (fwd_on && vy != 0) begin
      ax   = (vx < 0) ? -vx : vx;
      err  = heading_error_q12(ax, vy);
      aerr = (err < 0) ? -err : err;
      yaw  = yaw + ((heading_gain * err + 2048) >>> 12);
      if (yaw > 32767) yaw = 32767;
      if (yaw < -32768) yaw = -32768;
      vy = 0;
      if (aerr >= turn_only_thr) vx = 0;
    end
    vx      = clamp_to(vx, fwd_limit);
    vy      = clamp_to(vy, lat_limit);
    yaw_lim = turn_limit;
    if (fwd_on && fwd_turn_cap < yaw_lim) yaw_lim = fwd_turn_cap;
    yaw = clamp_to(yaw, yaw_lim);
    if (mode_bits[vcs_pkg::MODE_DB_BIT]) begin
      vx  = apply_deadband(vx, db_field(0), db_field(3));
      vy  = apply_deadband(vy, db_field(1), db_field(4));
      yaw = apply_deadband(yaw, db_field(2), db_field(5));
    end
    r.forward = vcs_pkg::VEL_W'(vx);
    r.lateral = vcs_pkg::VEL_W'(vy);
    r.turn    = vcs_pkg::VEL_W'(yaw);
    return r;
  endfunction

  // ---------------------------------------------------------------- table
  function automatic void add_cmd(int f, int l, int t);
    row_t r;
    r.kind  = ROW_ITEM;
    r.known = 1'b0;
    r.idx   = vcs_pkg::REG_MODE;
    r.value = '0;
    r.cmd   = '{vcs_pkg::VEL_W'(f), vcs_pkg::VEL_W'(l), vcs_pkg::VEL_W'(t)};
    r.want  = '0;
    directed.push_back(r);
  endfunction

  function automatic void add_known(int f, int l, int t, int ef, int el, int et);
    row_t r;
    r.kind  = ROW_ITEM;
    r.known = 1'b1;
    r.idx   = vcs_pkg::REG_MODE;
    r.value = '0;
    r.cmd   = '{vcs_pkg::VEL_W'(f), vcs_pkg::VEL_W'(l), vcs_pkg::VEL_W'(t)};
    r.want  = '{vcs_pkg::VEL_W'(ef), vcs_pkg::VEL_W'(el), vcs_pkg::VEL_W'(et)};
    directed.push_back(r);
  endfunction

  function automatic void add_reg(vcs_pkg::cfg_idx_t idx,
                                  logic [vcs_pkg::CFG_W-1:0] value);
    row_t r;
    r.kind  = ROW_REG;
    r.known = 1'b0;
    r.idx   = idx;
    r.value = value;
    r.cmd   = '0;
    r.want  = '0;
    directed.push_back(r);
  endfunction

  // ---------------------------------------------------------------- random
  function automatic logic signed [vcs_pkg::VEL_W-1:0] random_velocity();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(4))
          0:       return vcs_pkg::VEL_W'(-32768);
          1:       return vcs_pkg::VEL_W'(32767);
          2:       return '0;
          3:       return vcs_pkg::VEL_W'(1);
          default: return vcs_pkg::VEL_W'(-1);
        endcase
      end
      1, 2, 3: return vcs_pkg::VEL_W'(int'($urandom_range(3000)) - 1500);
      4, 5:    return vcs_pkg::VEL_W'(int'($urandom_range(32768)) - 16384);
      default: return vcs_pkg::VEL_W'($urandom());
    endcase
  endfunction

  function automatic vel_cmd_t random_command();
    vel_cmd_t c;
    c.forward = random_velocity();
    c.lateral = random_velocity();
    c.turn    = random_velocity();
    if ($urandom_range(4) == 0) c.lateral = '0;
    if ($urandom_range(7) == 0) c.forward = '0;
    return c;
  endfunction

  function automatic logic [vcs_pkg::CFG_W-1:0] random_limit();
    case ($urandom_range(4))
      0:       return '0;
      1:       return vcs_pkg::CFG_W'(32767);
      2, 3:    return vcs_pkg::CFG_W'($urandom_range(8191, 1));
      default: return vcs_pkg::CFG_W'($urandom_range(32767));
    endcase
  endfunction

  function automatic logic [vcs_pkg::CFG_W-1:0] random_deadband();
    logic [vcs_pkg::CFG_W-1:0] v;
    logic [vcs_pkg::DB_W-1:0]  f;
    int                        k;
    v = '0;
    for (k = 0; k < 6; k++) begin
      case ($urandom_range(3))
        0:       f = '0;
        1:       f = '1;
        2:       f = vcs_pkg::DB_W'($urandom_range(255));
        default: f = vcs_pkg::DB_W'($urandom());
      endcase
      v[k*vcs_pkg::DB_W +: vcs_pkg::DB_W] = f;
    end
    return v;
  endfunction

  // ---------------------------------------------------------------- driving
  task automatic write_reg(input vcs_pkg::cfg_idx_t idx,
                           input logic [vcs_pkg::CFG_W-1:0] value);
    case (idx)
      vcs_pkg::REG_MODE:     mode_bits     = longint'(value[vcs_pkg::MODE_W-1:0]);
      vcs_pkg::REG_MAX_FWD:  fwd_limit     = longint'(value[vcs_pkg::LIM_W-1:0]);
      vcs_pkg::REG_MAX_LAT:  lat_limit     = longint'(value[vcs_pkg::LIM_W-1:0]);
      vcs_pkg::REG_MAX_TURN: turn_limit    = longint'(value[vcs_pkg::LIM_W-1:0]);
      vcs_pkg::REG_FWD_CAP:  fwd_turn_cap  = longint'(value[vcs_pkg::LIM_W-1:0]);
      vcs_pkg::REG_GAIN:     heading_gain  = longint'(value[vcs_pkg::GAIN_W-1:0]);
      vcs_pkg::REG_TOA:      turn_only_thr = longint'(value[vcs_pkg::TOA_W-1:0]);
      vcs_pkg::REG_DEADBAND: db_fields     = value;
      default: ;
    endcase
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic randomize_config();
    int toa_pick;
    toa_pick = $urandom_range(3);
    write_reg(vcs_pkg::REG_MODE, vcs_pkg::CFG_W'($urandom_range(3)));
    write_reg(vcs_pkg::REG_MAX_FWD, random_limit());
    write_reg(vcs_pkg::REG_MAX_LAT, random_limit());
    write_reg(vcs_pkg::REG_MAX_TURN, random_limit());
    write_reg(vcs_pkg::REG_FWD_CAP, random_limit());
    write_reg(vcs_pkg::REG_GAIN,
              ($urandom_range(3) == 0) ? vcs_pkg::CFG_W'(65535 * $urandom_range(1))
                                       : vcs_pkg::CFG_W'($urandom_range(65535)));
    write_reg(vcs_pkg::REG_TOA,
              (toa_pick == 0) ? vcs_pkg::CFG_W'(6434 * $urandom_range(1)) :
              (toa_pick == 1) ? vcs_pkg::CFG_W'(8191) :
                                vcs_pkg::CFG_W'($urandom_range(6434)));
    write_reg(vcs_pkg::REG_DEADBAND, random_deadband());
    cfg_we_i <= 1'b0;
  endtask

  task automatic offer_command(input vel_cmd_t c, input bit known, input vel_out_t want);
    int       gap;
    vel_out_t shaped;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < gap_pct) gap++;
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.cmd_forward <= c.forward;
    cmd_bus.cmd_lateral <= c.lateral;
    cmd_bus.cmd_turn    <= c.turn;
    shaped = known ? want : shape_command(c);
    do @(posedge clk_i); while (!cmd_bus.ready);
    pending_shaped.push_back(shaped);
  endtask

  task automatic settle_block();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending_shaped.size() != 0);
  endtask

  // ---------------------------------------------------------------- checking
  task automatic check_shaped(input vel_out_t got);
    vel_out_t want;
    if (pending_shaped.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: unexpected item expected none actual fwd=%0d lat=%0d turn=%0d",
                 $time, got.forward, got.lateral, got.turn);
      return;
    end
    want = pending_shaped.pop_front();
    if (got != want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        if (got.forward != want.forward)
          $display("%0t: out_forward expected %0d actual %0d",
                   $time, want.forward, got.forward);
        if (got.lateral != want.lateral)
          $display("%0t: out_lateral expected %0d actual %0d",
                   $time, want.lateral, got.lateral);
        if (got.turn != want.turn)
          $display("%0t: out_turn expected %0d actual %0d",
                   $time, want.turn, got.turn);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready)
        check_shaped(vel_out_t'{res_bus.out_forward, res_bus.out_lateral,
                                res_bus.out_turn});
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: run timed out", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus
  initial begin : stimulus
    int r;
    int p;
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= vcs_pkg::REG_MODE;
    cfg_data_i          <= '0;
    cmd_bus.valid       <= 1'b0;
    cmd_bus.cmd_forward <= '0;
    cmd_bus.cmd_lateral <= '0;
    cmd_bus.cmd_turn    <= '0;
    gap_pct        = 0;
    stall_pct      = 0;
    hold_requests  = 0;
    mode_bits      = 3;
    fwd_limit      = 12288;
    lat_limit      = 4096;
    turn_limit     = 12288;
    fwd_turn_cap   = 2662;
    heading_gain   = 4915;
    turn_only_thr  = 1787;
    db_fields      = vcs_pkg::CFG_W'(64'd139026912467170427);

    // reset settings: deadband on, forward mode on
    add_known(0, 0, 0, 0, 0, 0);
    add_known(32767, 0, 0, 12288, 0, 0);
    add_known(-32768, 0, 0, -12288, 0, 0);
    add_known(0, 0, 32767, 0, 0, 2662);
    add_known(0, 0, -32768, 0, 0, -2662);
    add_cmd(1000, 0, 0);
    add_cmd(1000, 1, 0);
    add_cmd(1000, -1, 0);
    add_cmd(0, 500, 0);
    add_cmd(0, -500, 0);
    add_cmd(-32768, 32767, 32767);
    add_cmd(32767, -32768, -32768);
    add_cmd(200, 0, 100);
    // forward cap of zero leaves turn unclamped
    add_reg(vcs_pkg::REG_FWD_CAP, '0);
    add_known(0, 0, 32767, 0, 0, 32767);
    // full gain saturates turn, zero turn-only angle drops forward
    add_reg(vcs_pkg::REG_GAIN, vcs_pkg::CFG_W'(65535));
    add_reg(vcs_pkg::REG_TOA, '0);
    add_cmd(5000, 3000, 30000);
    add_cmd(5000, -3000, -30000);
    add_reg(vcs_pkg::REG_MODE, '0);
    add_known(300, -32768, 500, 300, -4096, 500);
    add_reg(vcs_pkg::REG_MAX_FWD, '0);
    add_reg(vcs_pkg::REG_MAX_LAT, '0);
    add_reg(vcs_pkg::REG_MAX_TURN, '0);
    add_known(-32768, -32768, -32768, -32768, -32768, -32768);
    add_known(32767, 32767, 32767, 32767, 32767, 32767);
    // zero threshold 0 with a nonzero minimum raises a zero axis
    add_reg(vcs_pkg::REG_MODE, vcs_pkg::CFG_W'(1));
    add_reg(vcs_pkg::REG_DEADBAND, DB_RAISE);
    add_known(0, 0, 0, 300, 1023, 1);
    add_known(-5, 5, -1, -300, 1023, -1);
    add_reg(vcs_pkg::REG_DEADBAND, '1);
    add_cmd(1022, -1023, 500);
    add_reg(vcs_pkg::REG_MODE, vcs_pkg::CFG_W'(2));
    add_reg(vcs_pkg::REG_TOA, vcs_pkg::CFG_W'(6434));
    add_reg(vcs_pkg::REG_GAIN, vcs_pkg::CFG_W'(4096));
    add_reg(vcs_pkg::REG_MAX_TURN, vcs_pkg::CFG_W'(32767));
    add_reg(vcs_pkg::REG_FWD_CAP, vcs_pkg::CFG_W'(32767));
    add_cmd(-100, 100, 0);
    add_cmd(32767, 1, -32768);
    add_cmd(0, -32768, 100);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < directed.size(); r++) begin
      if (directed[r].kind == ROW_REG) begin
        if (r == 0 || directed[r-1].kind != ROW_REG) settle_block();
        write_reg(directed[r].idx, directed[r].value);
        if (r == directed.size() - 1 || directed[r+1].kind != ROW_REG) cfg_we_i <= 1'b0;
      end else begin
        offer_command(directed[r].cmd, directed[r].known, directed[r].want);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      settle_block();
      randomize_config();
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 55; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 55; end
        default: begin gap_pct = 26; stall_pct = 26; end
      endcase
      if (p == PRESSURE_PHASE) hold_requests++;
      repeat (ITEMS_PER_PHASE) offer_command(random_command(), 1'b0, '0);
    end

    stall_pct = 0;
    settle_block();
    repeat (3 * PIPE_LATENCY) @(posedge clk_i);
    if (mismatch_count == 0 && pending_shaped.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== velocity_command_shaper_unit.f =====
+incdir+hdl
hdl/vcs_pkg.sv
hdl/vcs_cmd_if.sv
hdl/vcs_out_if.sv
hdl/vcs_cordic_stage.sv
hdl/velocity_command_shaper_unit.sv
verif/tb_velocity_command_shaper_unit.sv
